@@ rtl/core/box_intersection_over_union_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Box IoU assertion macros
// Shared concurrent-check templates, sampled on clock and idle in reset.
// ----------------------------------------------------------------------------
`ifndef BOX_INTERSECTION_OVER_UNION_UNIT_DEFINES_SVH
`define BOX_INTERSECTION_OVER_UNION_UNIT_DEFINES_SVH

// same-cycle implication
`define BIOU_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("box iou check failed");

// implication after a fixed number of cycles
`define BIOU_ASSERT_DELAY(label, ante, n, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error("box iou latency check failed");

`endif

@@ rtl/core/biou_pkg.sv @@
// ----------------------------------------------------------------------------
// Box IoU package
// Widths, request and response payloads and the divider cell state.
// ----------------------------------------------------------------------------
package biou_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int RATIO_WIDTH  = 16;
   localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
   localparam int PROD_WIDTH   = 2 * DIFF_WIDTH;
   localparam int INTER_WIDTH  = 2 * COORD_WIDTH;
   localparam int UNION_WIDTH  = PROD_WIDTH + 2;
   localparam int DIV_WIDTH    = UNION_WIDTH - 1;
   localparam int FRONT_STAGES = 3;
   localparam int LATENCY      = FRONT_STAGES + RATIO_WIDTH + 1;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] box_a_left;
      logic signed [COORD_WIDTH-1:0] box_a_top;
      logic signed [COORD_WIDTH-1:0] box_a_right;
      logic signed [COORD_WIDTH-1:0] box_a_bottom;
      logic signed [COORD_WIDTH-1:0] box_b_left;
      logic signed [COORD_WIDTH-1:0] box_b_top;
      logic signed [COORD_WIDTH-1:0] box_b_right;
      logic signed [COORD_WIDTH-1:0] box_b_bottom;
   } req_type;

   typedef struct packed {
      logic [RATIO_WIDTH-1:0] overlap_ratio;
      logic                   empty_union;
   } rsp_type;

   typedef struct packed {
      logic [DIV_WIDTH-1:0]   rem;
      logic [DIV_WIDTH-1:0]   divisor;
      logic [RATIO_WIDTH-1:0] quot;
      logic                   empty;
      logic                   sat;
   } div_state_type;

endpackage

@@ rtl/core/biou_front.sv @@
// ----------------------------------------------------------------------------
// Box IoU front end
// Three stages: edge differences, area products, union and ratio flags.
// ----------------------------------------------------------------------------
module biou_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  biou_pkg::req_type       in_req,
   output logic                    out_valid,
   output biou_pkg::div_state_type out_state
);
   import biou_pkg::*;

   logic                          v1_ff, v2_ff, v3_ff;
   logic        [COORD_WIDTH-1:0] iw_ff, ih_ff, iw_in, ih_in;
   logic signed [DIFF_WIDTH-1:0]  wa_ff, ha_ff, wb_ff, hb_ff;
   logic signed [DIFF_WIDTH-1:0]  wa_in, ha_in, wb_in, hb_in;
   logic signed [COORD_WIDTH-1:0] x1, x2, y1, y2;
   logic signed [DIFF_WIDTH-1:0]  iw_full, ih_full;
   logic        [INTER_WIDTH-1:0] inter_ff, inter_in;
   logic signed [PROD_WIDTH-1:0]  area_a_ff, area_b_ff, area_a_in, area_b_in;
   logic signed [UNION_WIDTH-1:0] inter_ext, uni;
   div_state_type                 state_ff, state_in;

   // stage 1: overlap extents and box sides
   always_comb begin
      x1 = (in_req.box_a_left > in_req.box_b_left) ? in_req.box_a_left : in_req.box_b_left;
      x2 = (in_req.box_a_right < in_req.box_b_right) ? in_req.box_a_right
                                                     : in_req.box_b_right;
      y1 = (in_req.box_a_top < in_req.box_b_top) ? in_req.box_a_top : in_req.box_b_top;
      y2 = (in_req.box_a_bottom > in_req.box_b_bottom) ? in_req.box_a_bottom
                                                       : in_req.box_b_bottom;
      iw_full = DIFF_WIDTH'(x2) - DIFF_WIDTH'(x1);
      ih_full = DIFF_WIDTH'(y1) - DIFF_WIDTH'(y2);
      // clamp empty overlap at zero
      iw_in = (!iw_full[DIFF_WIDTH-1] && iw_full != '0) ? iw_full[COORD_WIDTH-1:0] : '0;
      ih_in = (!ih_full[DIFF_WIDTH-1] && ih_full != '0) ? ih_full[COORD_WIDTH-1:0] : '0;
      wa_in = DIFF_WIDTH'(in_req.box_a_right) - DIFF_WIDTH'(in_req.box_a_left);
      ha_in = DIFF_WIDTH'(in_req.box_a_top)   - DIFF_WIDTH'(in_req.box_a_bottom);
      wb_in = DIFF_WIDTH'(in_req.box_b_right) - DIFF_WIDTH'(in_req.box_b_left);
      hb_in = DIFF_WIDTH'(in_req.box_b_top)   - DIFF_WIDTH'(in_req.box_b_bottom);
   end

   // stage 2: three products
   always_comb begin
      inter_in  = INTER_WIDTH'(iw_ff) * INTER_WIDTH'(ih_ff);
      area_a_in = PROD_WIDTH'(wa_ff) * PROD_WIDTH'(ha_ff);
      area_b_in = PROD_WIDTH'(wb_ff) * PROD_WIDTH'(hb_ff);
   end

   // stage 3: union, empty and saturation flags, divider seed
   always_comb begin
      inter_ext        = signed'(UNION_WIDTH'(inter_ff));
      uni              = UNION_WIDTH'(area_a_ff) + UNION_WIDTH'(area_b_ff) - inter_ext;
      state_in.empty   = uni[UNION_WIDTH-1] || (uni == '0);
      state_in.sat     = (inter_ext >= uni);
      state_in.rem     = DIV_WIDTH'(inter_ff);
      state_in.divisor = uni[DIV_WIDTH-1:0];
      state_in.quot    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      iw_ff     <= iw_in;
      ih_ff     <= ih_in;
      wa_ff     <= wa_in;
      ha_ff     <= ha_in;
      wb_ff     <= wb_in;
      hb_ff     <= hb_in;
      inter_ff  <= inter_in;
      area_a_ff <= area_a_in;
      area_b_ff <= area_b_in;
      state_ff  <= state_in;
   end

   assign out_valid = v3_ff;
   assign out_state = state_ff;

endmodule

@@ rtl/core/biou_div_cell.sv @@
// ----------------------------------------------------------------------------
// Box IoU divider cell
// One restoring-division step: shift the partial remainder, subtract, emit a bit.
// ----------------------------------------------------------------------------
module biou_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  biou_pkg::div_state_type in_state,
   output logic                    out_valid,
   output biou_pkg::div_state_type out_state
);
   import biou_pkg::*;

   logic                 valid_ff;
   div_state_type        state_ff, state_in;
   logic [DIV_WIDTH:0]   shifted, diff;
   logic                 ge;

   always_comb begin
      shifted  = {in_state.rem, 1'b0};
      diff     = shifted - {1'b0, in_state.divisor};
      ge       = (shifted >= {1'b0, in_state.divisor});
      state_in = in_state;
      state_in.rem  = ge ? diff[DIV_WIDTH-1:0] : shifted[DIV_WIDTH-1:0];
      state_in.quot = {in_state.quot[RATIO_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      state_ff <= state_in;
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

@@ rtl/core/box_intersection_over_union_unit.sv @@
// ----------------------------------------------------------------------------
// Box intersection over union unit
// Ratio of overlap area to union area of two boxes, one pair per cycle.
//
//   channel   ports                           direction   handshake
//   request   start, busy, req_payload        in          start && !busy
//   response  rsp_valid, rsp_payload          out         one-cycle strobe
//
// A request is taken in every cycle with start high and busy low; its response
// passes through three front stages, one divider cell per ratio bit and the
// output register. busy is high only during reset.
// Reset is synchronous and clears all valid bits; payload registers keep data.
// The response side cannot stall, so nothing in the pipe ever holds.
// ----------------------------------------------------------------------------
`include "box_intersection_over_union_unit_defines.svh"

module box_intersection_over_union_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  biou_pkg::req_type req_payload,
   output logic              rsp_valid,
   output biou_pkg::rsp_type rsp_payload
);
   import biou_pkg::*;

   logic          cell_valid [RATIO_WIDTH+1];
   div_state_type cell_state [RATIO_WIDTH+1];
   logic          rsp_valid_ff;
   rsp_type       rsp_payload_ff, rsp_payload_in;
   logic          accept;
   div_state_type last;

   assign busy   = reset;
   assign accept = start && !busy;

   biou_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_payload),
      .out_valid (cell_valid[0]),
      .out_state (cell_state[0])
   );

   for (genvar i = 0; i < RATIO_WIDTH; i++) begin : g_cell
      biou_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[i]),
         .in_state  (cell_state[i]),
         .out_valid (cell_valid[i+1]),
         .out_state (cell_state[i+1])
      );
   end

   // drop the quotient when the union is empty or the ratio reaches one
   always_comb begin
      last = cell_state[RATIO_WIDTH];
      rsp_payload_in.empty_union = last.empty;
      if (last.empty) begin
         rsp_payload_in.overlap_ratio = '0;
      end else if (last.sat) begin
         rsp_payload_in.overlap_ratio = '1;
      end else begin
         rsp_payload_in.overlap_ratio = last.quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cell_valid[RATIO_WIDTH];
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `BIOU_ASSERT_DELAY(a_request_answered, accept, LATENCY, rsp_valid)
   `BIOU_ASSERT_IMP(a_no_invented_rsp, rsp_valid, $past(accept, LATENCY))
   `BIOU_ASSERT_DELAY(a_chain_valid, cell_valid[0], RATIO_WIDTH, cell_valid[RATIO_WIDTH])

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Box intersection over union unit testbench
// Sends box pairs through the command port with random gaps and bursts, then
// predicts each overlap ratio and empty-union flag and checks every response
// in order against the prediction.
// ----------------------------------------------------------------------------
module testbench;
   import biou_pkg::*;

   localparam int RATIO_MAX = (1 << RATIO_WIDTH) - 1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_valid;
   rsp_type rsp_payload;

   rsp_type pending_ratios[$];
   int      error_count = 0;
   bit      burst_mode = 1'b0;

   box_intersection_over_union_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   // Exact integer IoU: every product fits well inside 64 bits.
   function automatic rsp_type predict_overlap(req_type r);
      longint  al, at, ar, ab, bl, bt, br, bb;
      longint  x_lo, x_hi, y_hi, y_lo, over_w, over_h;
      longint  inter_area, union_area;
      rsp_type p;
      al = longint'($signed(r.box_a_left));
      at = longint'($signed(r.box_a_top));
      ar = longint'($signed(r.box_a_right));
      ab = longint'($signed(r.box_a_bottom));
      bl = longint'($signed(r.box_b_left));
      bt = longint'($signed(r.box_b_top));
      br = longint'($signed(r.box_b_right));
      bb = longint'($signed(r.box_b_bottom));
      x_lo = (al > bl) ? al : bl;
      x_hi = (ar < br) ? ar : br;
      y_hi = (at < bt) ? at : bt;
      y_lo = (ab > bb) ? ab : bb;
      over_w = (x_hi > x_lo) ? x_hi - x_lo : 0;
      over_h = (y_hi > y_lo) ? y_hi - y_lo : 0;
      inter_area = over_w * over_h;
      // inverted boxes keep their signed area
      union_area = (ar - al) * (at - ab) + (br - bl) * (bt - bb) - inter_area;
      p = '0;
      if (union_area <= 0) begin
         p.empty_union = 1'b1;
      end else if (inter_area >= union_area) begin
         p.overlap_ratio = RATIO_MAX[RATIO_WIDTH-1:0];
      end else begin
         p.overlap_ratio = RATIO_WIDTH'((inter_area <<< RATIO_WIDTH) / union_area);
      end
      return p;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return COORD_WIDTH'(v);
   endfunction

   function automatic req_type make_pair(longint al, longint at, longint ar, longint ab,
                                         longint bl, longint bt, longint br, longint bb);
      req_type r;
      r.box_a_left   = clamp_coord(al);
      r.box_a_top    = clamp_coord(at);
      r.box_a_right  = clamp_coord(ar);
      r.box_a_bottom = clamp_coord(ab);
      r.box_b_left   = clamp_coord(bl);
      r.box_b_top    = clamp_coord(bt);
      r.box_b_right  = clamp_coord(br);
      r.box_b_bottom = clamp_coord(bb);
      return r;
   endfunction

   // Well-formed pair: box b sits near box a so most pairs overlap.
   function automatic req_type random_overlap_pair();
      longint ax, ay, aw, ah, bx, by, bw, bh;
      aw = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 4096);
      ah = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 4096);
      ax = longint'($urandom_range(0, 65535)) - 32768;
      ay = longint'($urandom_range(0, 65535)) - 32768;
      bw = aw / 2 + $urandom_range(0, aw);
      bh = ah / 2 + $urandom_range(0, ah);
      bx = ax + longint'($urandom_range(0, 2 * aw)) - aw;
      by = ay + longint'($urandom_range(0, 2 * ah)) - ah;
      return make_pair(ax, ay + ah, ax + aw, ay, bx, by + bh, bx + bw, by);
   endfunction

   function automatic req_type random_broken_pair();
      req_type r;
      logic signed [COORD_WIDTH-1:0] hold;
      r = random_overlap_pair();
      case ($urandom_range(0, 4))
         0: begin
            hold = r.box_a_left;
            r.box_a_left = r.box_a_right;
            r.box_a_right = hold;
         end
         1: begin
            hold = r.box_b_top;
            r.box_b_top = r.box_b_bottom;
            r.box_b_bottom = hold;
         end
         2: r.box_a_right = r.box_a_left;
         3: r.box_b_top = r.box_b_bottom;
         default: begin
            // flip both axes of b: positive area but no overlap possible
            hold = r.box_b_left;
            r.box_b_left = r.box_b_right;
            r.box_b_right = hold;
            hold = r.box_b_top;
            r.box_b_top = r.box_b_bottom;
            r.box_b_bottom = hold;
         end
      endcase
      return r;
   endfunction

   function automatic int sender_gap();
      return burst_mode ? 0 : $urandom_range(0, 5);
   endfunction

   // Hold start until the request is taken, then queue its prediction.
   task automatic send_pair(input req_type r, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      pending_ratios = {pending_ratios, predict_overlap(r)};
   endtask

   task automatic drain_ratios();
      @(negedge clock);
      start <= 1'b0;
      while (pending_ratios.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (rsp_valid !== 1'b1) begin
            $error("rsp_valid unknown: %b", rsp_valid);
            error_count++;
         end else if (pending_ratios.size() == 0) begin
            $error("response with no request outstanding: ratio %0d empty %0d",
                   rsp_payload.overlap_ratio, rsp_payload.empty_union);
            error_count++;
         end else begin
            want = pending_ratios.pop_front();
            if (rsp_payload.overlap_ratio !== want.overlap_ratio) begin
               $error("overlap_ratio expected %0d actual %0d",
                      want.overlap_ratio, rsp_payload.overlap_ratio);
               error_count++;
            end
            if (rsp_payload.empty_union !== want.empty_union) begin
               $error("empty_union expected %0d actual %0d",
                      want.empty_union, rsp_payload.empty_union);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed_geometry();
      // identical boxes: ratio of exactly one saturates
      send_pair(make_pair(0, 4096, 4096, 0, 0, 4096, 4096, 0), sender_gap());
      // disjoint boxes
      send_pair(make_pair(0, 4096, 4096, 0, 8192, 12288, 12288, 8192), sender_gap());
      // half-width shift: one third
      send_pair(make_pair(0, 4096, 4096, 0, 2048, 4096, 6144, 0), sender_gap());
      // b inside a: one quarter
      send_pair(make_pair(0, 8192, 8192, 0, 0, 4096, 4096, 0), sender_gap());
      // touching edges give zero overlap
      send_pair(make_pair(0, 4096, 4096, 0, 4096, 4096, 8192, 0), sender_gap());
      // zero-area boxes: empty union
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0), sender_gap());
      send_pair(make_pair(100, 900, 100, 0, -50, 7, 300, 7), sender_gap());
      // both boxes inverted, b on both axes: positive union, ratio zero
      send_pair(make_pair(4096, 4096, 0, 0, 8192, 0, 0, 8192), sender_gap());
      // inverted a outweighs b: negative union
      send_pair(make_pair(8192, 8192, 0, 0, 0, 1024, 1024, 0), sender_gap());
      // inverted a cancels b exactly: zero union
      send_pair(make_pair(4096, 4096, 0, 0, 0, 4096, 4096, 0), sender_gap());
      // a inverted on both axes: positive area, no overlap
      send_pair(make_pair(8192, 0, 0, 8192, 0, 8192, 8192, 0), sender_gap());
      // inverted a smaller than b: positive union, ratio zero
      send_pair(make_pair(1024, 1024, 0, 0, 0, 8192, 8192, 0), sender_gap());
      // full range boxes
      send_pair(make_pair(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768),
                sender_gap());
      send_pair(make_pair(-32768, 32767, 32767, -32768, -32768, 32766, 32767, -32768),
                sender_gap());
      send_pair(make_pair(-32768, 32767, 32767, -32768, 0, 1, 1, 0), sender_gap());
      // one unit of overlap gives a ratio of one LSB
      send_pair(make_pair(-32768, 32767, 0, -32768, -1, 32767, 32767, -32768), sender_gap());
      // all fields at an extreme
      send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
                sender_gap());
      send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
                sender_gap());
      send_pair(make_pair(32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768),
                sender_gap());
      // largest inverted magnitudes on both
      send_pair(make_pair(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767),
                sender_gap());
   endtask

   task automatic test_back_to_back();
      burst_mode = 1'b1;
      repeat (40) send_pair(random_overlap_pair(), sender_gap());
      burst_mode = 1'b0;
   endtask

   task automatic test_pause_until_drained();
      repeat (10) send_pair(random_overlap_pair(), sender_gap());
      drain_ratios();
      repeat (10) send_pair(random_overlap_pair(), 0);
   endtask

   task automatic test_random_pairs();
      int pick;
      repeat (780) begin
         if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            send_pair(random_overlap_pair(), sender_gap());
         end else if (pick < 84) begin
            send_pair(req_type'({$urandom, $urandom, $urandom, $urandom}), sender_gap());
         end else begin
            send_pair(random_broken_pair(), sender_gap());
         end
      end
      burst_mode = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_geometry();
      test_back_to_back();
      test_pause_until_drained();
      test_random_pairs();
      drain_ratios();
      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
